@@ rtl/s4rf_pkg.sv @@
package s4rf_pkg;

	// Default table depth.
	localparam int NUM_RULES_DEF = 16;

	// SOCKS4 command and reply codes.
	localparam logic [7:0] CMD_CONNECT   = 8'd1;
	localparam logic [7:0] CMD_BIND      = 8'd2;
	localparam logic [6:0] CODE_GRANTED  = 7'd90;
	localparam logic [6:0] CODE_REJECTED = 7'd91;

	// Values of the tuser selector on the request side.
	localparam logic MODE_RULE    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 64;
	localparam int CFG_W     = 16;

	// Request-side payload, declared from the top bit down so that the
	// first field lands in the lowest bits of tdata.
	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] req_ip;
		logic [15:0] req_port;
		logic [7:0]  req_command;
		logic [3:0]  rule_wildcards;
		logic [31:0] rule_octets;
		logic        rule_is_connect;
		logic        rule_permit;
		logic        rule_valid;
		logic [3:0]  rule_index;
	} in_item_t;

	// Reply-side payload, first field in the lowest bits.
	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] reply_ip;
		logic [15:0] reply_port;
		logic [6:0]  reply_code;
		logic [3:0]  match_index;
		logic        matched;
		logic        granted;
	} out_item_t;

	// One stored rule body.
	typedef struct packed {
		logic        permit;
		logic        is_connect;
		logic [31:0] octets;
		logic [3:0]  wildcards;
	} rule_body_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write_rule;
		logic start;
		logic advance;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/s4rf_ctrl.sv @@
module s4rf_ctrl
	import s4rf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tuser,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d        = state_q;
		cmd.write_rule = 1'b0;
		cmd.start      = 1'b0;
		cmd.advance    = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == MODE_REQUEST) begin
						cmd.start = 1'b1;
						state_d   = ST_WALK;
					end else begin
						cmd.write_rule = 1'b1;
					end
				end
			end
			ST_WALK: begin
				// The walk freezes on a decision until the reply register frees up.
				cmd.advance = !status.done;
				if (status.done && status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/s4rf_datapath.sv @@
module s4rf_datapath
	import s4rf_pkg::*;
#(
	parameter int NUM_RULES = NUM_RULES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status
);

	localparam int AW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_RULES - 1);

	in_item_t               item;
	logic                   wr_ok;
	logic [AW-1:0]          wr_addr;

	rule_body_t             rule_mem [NUM_RULES];
	logic [NUM_RULES-1:0]   in_use_q;
	logic [CFG_W-1:0]       bind_port_q;

	logic [7:0]             req_cmd_q;
	logic [15:0]            req_port_q;
	logic [31:0]            req_ip_q;

	logic [AW-1:0]          cnt_q;
	logic                   issue_on_q;
	logic                   rd_vld_s1;
	logic                   rd_use_s1;
	logic [AW-1:0]          rd_idx_s1;
	rule_body_t             rd_body_s1;

	logic [3:0]             oct_ok;
	logic                   cmd_ok;
	logic                   hit;
	logic                   last;
	logic                   granted;

	logic                   m_tvalid_q;
	out_item_t              m_item_q;

	assign item    = in_item_t'(s_tdata);
	assign wr_ok   = ({3'd0, item.rule_index} < 7'(NUM_RULES));
	assign wr_addr = AW'(item.rule_index);

	// Rule table storage; the body is payload, the in-use bits are control.
	always_ff @(posedge clk) begin
		if (cmd.write_rule && wr_ok) begin
			rule_mem[wr_addr] <= '{permit:     item.rule_permit,
			                       is_connect: item.rule_is_connect,
			                       octets:     item.rule_octets,
			                       wildcards:  item.rule_wildcards};
		end
		if (cmd.advance && issue_on_q) begin
			rd_body_s1 <= rule_mem[cnt_q];
			rd_use_s1  <= in_use_q[cnt_q];
			rd_idx_s1  <= cnt_q;
		end
		if (cmd.start) begin
			req_cmd_q  <= item.req_command;
			req_port_q <= item.req_port;
			req_ip_q   <= item.req_ip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			bind_port_q <= '0;
			cnt_q       <= '0;
			issue_on_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cmd.write_rule && wr_ok) begin
				in_use_q[wr_addr] <= item.rule_valid;
			end
			if (cfg_wr_en) begin
				bind_port_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				cnt_q      <= '0;
				issue_on_q <= 1'b1;
				rd_vld_s1  <= 1'b0;
			end else if (cmd.advance) begin
				if (issue_on_q) begin
					rd_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						issue_on_q <= 1'b0;
					end
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end
		end
	end

	// Compare the rule held in the read register against the held request.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			oct_ok[k] = rd_body_s1.wildcards[k] ||
			            (rd_body_s1.octets[8*k +: 8] == req_ip_q[8*k +: 8]);
		end
	end

	assign cmd_ok  = ((rd_body_s1.is_connect ? CMD_CONNECT : CMD_BIND) == req_cmd_q);
	assign hit     = rd_vld_s1 && rd_use_s1 && cmd_ok && (&oct_ok);
	assign last    = rd_vld_s1 && (rd_idx_s1 == LAST);
	assign granted = hit && rd_body_s1.permit;

	assign status.done     = hit || last;
	assign status.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_item_q.pad         <= '0;
			m_item_q.granted     <= granted;
			m_item_q.matched     <= hit;
			m_item_q.match_index <= hit ? 4'(rd_idx_s1) : 4'd0;
			m_item_q.reply_code  <= granted ? CODE_GRANTED : CODE_REJECTED;
			if (granted && (req_cmd_q == CMD_BIND)) begin
				m_item_q.reply_port <= bind_port_q;
				m_item_q.reply_ip   <= '0;
			end else begin
				m_item_q.reply_port <= req_port_q;
				m_item_q.reply_ip   <= req_ip_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_item_q);

endmodule

@@ rtl/socks4_request_filter.sv @@
// First-match access control for SOCKS4 requests. Each request carries a
// selector on s_tuser: a rule write (0) loads one slot of a table of
// NUM_RULES rules in the cycle it is accepted and produces no reply, while
// a request check (1) walks the table from slot 0 upward, one rule per
// cycle through a registered read of the rule memory, and stops at the
// first rule that is in use, names the same command and matches all four
// destination octets or wildcards them. A check holds its decision until
// the reply register is free and then loads its reply there; one with
// no match loads a rejection after the last slot. The block takes its next
// request once the reply is loaded, even while that reply still waits on
// m_tready. The reply code is 90 when the matching rule permits and 91
// otherwise; a granted bind reports the bind port register and address
// zero, and every other reply echoes the requested port and address.
// The bind port register may be written only while no check is running.
module socks4_request_filter
	import s4rf_pkg::*;
#(
	parameter int NUM_RULES = NUM_RULES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,

	// Request side.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// From bit 0: rule_index[3:0], rule_valid, rule_permit, rule_is_connect,
	// rule_octets[31:0], rule_wildcards[3:0], req_command[7:0],
	// req_port[15:0], req_ip[31:0], zero fill to 104 bits.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode: 0 writes a rule, 1 checks a request.
	input  logic                 s_tuser,

	// Reply side.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// From bit 0: granted, matched, match_index[3:0], reply_code[6:0],
	// reply_port[15:0], reply_ip[31:0], zero fill to 64 bits.
	output logic [M_TDATA_W-1:0] m_tdata,

	// Bind port register write.
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The controller decides when a request is taken and when the walk
	// advances, stalls or delivers its reply.
	s4rf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the rule table, the request under check, the
	// compare stage and the reply register.
	s4rf_datapath #(
		.NUM_RULES (NUM_RULES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

@@ test/s4rf_reply_checker.sv @@
module s4rf_reply_checker
	import s4rf_pkg::*;
#(
	parameter int NUM_RULES = NUM_RULES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	output int                   fail_count,
	output int                   replies_pending,
	output int                   replies_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_CAP = 100;

	logic             slot_used [NUM_RULES];
	rule_body_t       slot_rule [NUM_RULES];
	logic [CFG_W-1:0] bind_port_q;
	out_item_t        replies_due [$];
	int               errs = 0;
	int               checked = 0;

	// Walks the rule slots from zero upward and builds the reply that the
	// first matching rule in use decides.
	function automatic out_item_t first_match_reply(in_item_t req);
		out_item_t  rep;
		logic [7:0] rule_cmd;
		logic       hit;
		logic       found;
		int         i;
		int         k;
		found = 1'b0;
		rep = '0;
		rep.reply_code = CODE_REJECTED;
		rep.reply_port = req.req_port;
		rep.reply_ip   = req.req_ip;
		for (i = 0; i < NUM_RULES; i++) begin
			if (!found && slot_used[i]) begin
				rule_cmd = slot_rule[i].is_connect ? CMD_CONNECT : CMD_BIND;
				hit = (rule_cmd == req.req_command);
				for (k = 0; k < 4; k++)
					if (!slot_rule[i].wildcards[k] &&
					    slot_rule[i].octets[8*k +: 8] != req.req_ip[8*k +: 8])
						hit = 1'b0;
				if (hit) begin
					found = 1'b1;
					rep.matched = 1'b1;
					rep.match_index = 4'(i);
					rep.granted = slot_rule[i].permit;
				end
			end
		end
		if (rep.granted) begin
			rep.reply_code = CODE_GRANTED;
			// A granted bind reports the listening port and no address.
			if (req.req_command == CMD_BIND) begin
				rep.reply_port = bind_port_q;
				rep.reply_ip = '0;
			end
		end
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (got !== want) begin
			errs++;
			if (errs <= REPORT_CAP)
				$display("%0t: reply %s mismatch, expected %0h, got %0h",
				         $time, name, want, got);
			else if (errs == REPORT_CAP + 1)
				$display("%0t: further mismatch reports suppressed", $time);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		in_item_t  req;
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			bind_port_q = '0;
			replies_due.delete();
		end else begin
			if (cfg_wr_en)
				bind_port_q = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				req = s_tdata;
				if (s_tuser == MODE_RULE) begin
					if (req.rule_index < NUM_RULES) begin
						slot_used[req.rule_index] = req.rule_valid;
						slot_rule[req.rule_index] = {req.rule_permit, req.rule_is_connect,
						                             req.rule_octets, req.rule_wildcards};
					end
				end else begin
					replies_due.push_back(first_match_reply(req));
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (replies_due.size() == 0) begin
					errs++;
					if (errs <= REPORT_CAP)
						$display("%0t: reply with none expected, expected none, got %h",
						         $time, got);
				end else begin
					want = replies_due.pop_front();
					checked++;
					compare_field("granted",     32'(want.granted),     32'(got.granted));
					compare_field("matched",     32'(want.matched),     32'(got.matched));
					compare_field("match_index", 32'(want.match_index), 32'(got.match_index));
					compare_field("reply_code",  32'(want.reply_code),  32'(got.reply_code));
					compare_field("reply_port",  32'(want.reply_port),  32'(got.reply_port));
					compare_field("reply_ip",    want.reply_ip,         got.reply_ip);
				end
			end
		end
		fail_count      <= errs;
		replies_pending <= replies_due.size();
		replies_checked <= checked;
	end

endmodule

@@ test/tb_socks4_request_filter.sv @@
module tb_socks4_request_filter import s4rf_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RULES     = NUM_RULES_DEF;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 260;
	localparam int HOLD_CYCLES   = 400;
	// A request that matches nothing walks every slot, so this covers the
	// slowest check plus the reply register.
	localparam int SETTLE_CYCLES = NUM_RULES + 4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = MODE_RULE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]     cfg_wr_data = '0;

	int fail_count;
	int replies_pending;
	int replies_checked;

	// When calm is set neither side idles. The hold request asks the reply
	// side to stall for a long stretch; that side clears it when done.
	bit calm = 1'b0;
	bit sink_hold_req = 1'b0;

	// Addresses last written into each slot. Requests aim at them so that
	// the walk often stops on a real rule instead of falling through.
	logic [31:0] slot_addr [NUM_RULES] = '{default: '0};

	int rule_writes = 0;
	int requests = 0;
	int bind_settings = 0;

	always #10 clk = ~clk;

	socks4_request_filter #(.NUM_RULES(NUM_RULES)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	s4rf_reply_checker #(.NUM_RULES(NUM_RULES)) reply_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.fail_count      (fail_count),
		.replies_pending (replies_pending),
		.replies_checked (replies_checked)
	);

	// Octets lean toward the edges and a few common network prefixes so
	// that rules and requests collide often.
	function automatic logic [7:0] pick_octet();
		case ($urandom_range(5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd10;
			3:       return 8'd192;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [31:0] random_addr();
		if ($urandom_range(3) == 0)
			return $urandom();
		return {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
	endfunction

	function automatic in_item_t rule_item(logic [3:0] slot, logic valid, logic permit,
	                                       logic is_connect, logic [31:0] octets,
	                                       logic [3:0] wild);
		in_item_t it;
		it = '0;
		it.rule_index      = slot;
		it.rule_valid      = valid;
		it.rule_permit     = permit;
		it.rule_is_connect = is_connect;
		it.rule_octets     = octets;
		it.rule_wildcards  = wild;
		return it;
	endfunction

	function automatic in_item_t request_item(logic [7:0] cmd, logic [15:0] port,
	                                          logic [31:0] ip);
		in_item_t it;
		it = '0;
		it.req_command = cmd;
		it.req_port    = port;
		it.req_ip      = ip;
		return it;
	endfunction

	// Offers one request and returns at the edge where it is accepted. The
	// valid stays high afterwards, so back-to-back requests never lower and
	// raise it within one time step; idle cycles and wait_idle drop it.
	task automatic send_item(input logic mode, input in_item_t it);
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_RULE) begin
			rule_writes++;
			slot_addr[it.rule_index] = it.rule_octets;
		end else begin
			requests++;
		end
	endtask

	// A quarter of the traffic rewrites rules, the rest are checks. Checks
	// mostly name a real command and an address near a stored rule, with a
	// share of odd command bytes and unrelated addresses.
	task automatic send_random_item();
		logic [31:0] ip;
		logic [7:0]  cmd;
		int          roll;
		int          k;
		if ($urandom_range(99) < 25) begin
			send_item(MODE_RULE, rule_item(4'($urandom_range(15)), $urandom_range(99) < 80,
			                               1'($urandom_range(1)), 1'($urandom_range(1)),
			                               random_addr(), 4'($urandom_range(15))));
		end else begin
			if ($urandom_range(99) < 65) begin
				ip = slot_addr[$urandom_range(NUM_RULES - 1)];
				for (k = 0; k < 4; k++)
					if ($urandom_range(99) < 15)
						ip[8*k +: 8] = pick_octet();
			end else begin
				ip = random_addr();
			end
			roll = $urandom_range(99);
			if (roll < 45)
				cmd = CMD_CONNECT;
			else if (roll < 88)
				cmd = CMD_BIND;
			else
				cmd = 8'($urandom_range(255));
			send_item(MODE_REQUEST, request_item(cmd, 16'($urandom), ip));
		end
	endtask

	// Stops offering, waits for every outstanding reply, then lets a full
	// table walk pass so that the block is surely idle. The first edge
	// lets the reply count catch up with a request accepted just now.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bind_port(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bind_settings++;
	endtask

	// Reply side. It stalls about a quarter of the time, not at all while
	// calm is set, and for one long stretch when the hold is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
			end
			m_tready <= calm || ($urandom_range(99) >= 24);
		end
	end

	initial begin
		int               p;
		logic [CFG_W-1:0] port_setting;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		set_bind_port(16'hFFFF);

		// Directed checks. The table starts empty, so the first two requests
		// fall through every slot, one of them with a command byte of zero.
		send_item(MODE_REQUEST, request_item(CMD_CONNECT, 16'h1234, 32'h0A00_0001));
		send_item(MODE_REQUEST, request_item(8'd0, 16'h0000, 32'h0000_0000));
		// Exact connect rule in slot 0: hit, wrong address, wrong command.
		send_item(MODE_RULE, rule_item(4'd0, 1'b1, 1'b1, 1'b1, 32'h0A00_0001, 4'b0000));
		send_item(MODE_REQUEST, request_item(CMD_CONNECT, 16'h0000, 32'h0A00_0001));
		send_item(MODE_REQUEST, request_item(CMD_CONNECT, 16'hFFFF, 32'h0A00_0002));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'h0050, 32'h0A00_0001));
		// Fully wildcarded permit-bind in slot 1: a granted bind replaces the
		// port with the register and clears the address.
		send_item(MODE_RULE, rule_item(4'd1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 4'b1111));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'h0000, 32'h0000_0000));
		// Reject rule for 192.*.*.*: matched but refused, reply echoes.
		send_item(MODE_RULE, rule_item(4'd2, 1'b1, 1'b0, 1'b1, 32'hC000_0000, 4'b0111));
		send_item(MODE_REQUEST, request_item(CMD_CONNECT, 16'd1080, 32'hC0A8_0101));
		// Catch-all connect in the last slot gives the longest matching walk.
		send_item(MODE_RULE, rule_item(4'd15, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 4'b1111));
		send_item(MODE_REQUEST, request_item(CMD_CONNECT, 16'd53, 32'h0808_0808));
		// Unknown command bytes match nothing, even with catch-alls present.
		send_item(MODE_REQUEST, request_item(8'd3, 16'd80, 32'h0808_0808));
		send_item(MODE_REQUEST, request_item(8'hFF, 16'd80, 32'hFFFF_FFFF));
		// Retiring the bind catch-all leaves binds unmatched.
		send_item(MODE_RULE, rule_item(4'd1, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 4'b1111));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'd8080, 32'h0102_0304));
		// A reject-bind with the first octet wildcarded ahead of an exact
		// permit-bind: each request here matches only one of them.
		send_item(MODE_RULE, rule_item(4'd3, 1'b1, 1'b0, 1'b0, 32'h007F_0001, 4'b1000));
		send_item(MODE_RULE, rule_item(4'd4, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 4'b0000));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'd7, 32'h017F_0001));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'd7, 32'hFFFF_FFFF));
		send_item(MODE_REQUEST, request_item(CMD_BIND, 16'd7, 32'hFF7F_0001));

		// Random phases, each under its own bind port. Every register change
		// drains the block first. Phase 1 runs with no idling on either
		// side; phase 3 opens with a long reply stall while requests keep
		// coming, which fills the block and backs up its input.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0:       port_setting = 16'h0000;
				1:       port_setting = 16'hFFFF;
				2:       port_setting = 16'h0438;
				3:       port_setting = 16'h8000;
				default: port_setting = 16'($urandom);
			endcase
			set_bind_port(port_setting);
			calm = (p == 1);
			if (p == 3)
				sink_hold_req = 1'b1;
			repeat (PHASE_ITEMS) send_random_item();
		end
		calm = 1'b0;

		wait_idle();

		$display("Run covered %0d rule writes and %0d access checks (%0d replies compared)",
		         rule_writes, requests, replies_checked);
		$display("under %0d bind port settings, with a %0d-cycle reply stall and a calm phase.",
		         bind_settings, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Overall limit, far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d replies still outstanding.", replies_pending);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
